>>> hw/rtl/sfta_pkg.sv
package sfta_pkg;

  // Command word and register widths
  localparam int unsigned WORD_W  = 16;
  localparam int unsigned INDEX_W = 15;
  localparam int unsigned TOTAL_W = 24;
  localparam int unsigned CFG_W   = 15;
  localparam int unsigned CFG_A_W = 2;

  // Default depth of the job queue between front and back
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;
  localparam logic [TOTAL_W-1:0] TOTAL_SAT = TOTAL_MAX - TOTAL_W'(3);

  // Result kind codes
  localparam logic KIND_VERTEX = 1'b0;
  localparam logic KIND_END    = 1'b1;

  // Configuration register indexes
  typedef enum logic [CFG_A_W-1:0] {
    CFG_TEX_WIDTH    = 2'd0,
    CFG_NORMAL_BASE  = 2'd1,
    CFG_VERTEX_LIMIT = 2'd2,
    CFG_NORMAL_LIMIT = 2'd3
  } cfg_idx_t;

  // Word position inside a vertex record
  typedef enum logic [1:0] {
    FLD_VERTEX = 2'd0,
    FLD_NORMAL = 2'd1,
    FLD_S      = 2'd2,
    FLD_T      = 2'd3
  } field_t;

  // Parser mode
  typedef enum logic {
    MODE_HEADER = 1'b0,
    MODE_RECORD = 1'b1
  } mode_t;

  typedef struct packed {
    logic [CFG_W-1:0] tex_width;
    logic [CFG_W-1:0] normal_base;
    logic [CFG_W-1:0] vertex_limit;
    logic [CFG_W-1:0] normal_limit;
  } cfg_t;

  // One adjusted vertex as it leaves the block
  typedef struct packed {
    logic [INDEX_W-1:0] v;
    logic [INDEX_W-1:0] n;
    logic [WORD_W-1:0]  s;
    logic [WORD_W-1:0]  t;
  } vrec_t;

  // One unit of work for the back end: a whole triangle or a mesh end
  typedef struct packed {
    logic               is_end;
    logic [TOTAL_W-1:0] total;
    vrec_t [2:0]        vtx;
  } job_t;

  // Queue status seen by the back end and the input handshake
  typedef struct packed {
    logic full;
    logic valid;
  } q_stat_t;

endpackage

>>> hw/rtl/sfta_front.sv
module sfta_front
  import sfta_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  cfg_t               cfg,
  input  logic               word_valid,
  input  logic [WORD_W-1:0]  word,
  output logic               push,
  output job_t               push_job
);

  mode_t              mode_r, mode_nxt;
  logic               is_fan_r, is_fan_nxt;
  logic [WORD_W:0]    remain_r, remain_nxt;
  logic [1:0]         ord_r, ord_nxt;
  logic               parity_r, parity_nxt;
  field_t             field_r, field_nxt;
  logic [TOTAL_W-1:0] emitted_r, emitted_nxt;

  // Record being assembled, adjusted field by field
  logic [INDEX_W-1:0] rv_r, rv_nxt;
  logic               vok_r, vok_nxt;
  logic [INDEX_W-1:0] rn_r, rn_nxt;
  logic               nok_r, nok_nxt;
  logic               seam_r, seam_nxt;
  logic [WORD_W-1:0]  rs_r, rs_nxt;

  // The two held vertices of the running strip or fan
  vrec_t              held0_r, held0_nxt, held1_r, held1_nxt;
  logic               ok0_r, ok0_nxt, ok1_r, ok1_nxt;

  logic [WORD_W:0]    mag;
  logic [WORD_W-1:0]  nadj;
  vrec_t              rec;
  logic               rec_ok;

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_HEADER;
      is_fan_r  <= 1'b0;
      remain_r  <= '0;
      ord_r     <= '0;
      parity_r  <= 1'b0;
      field_r   <= FLD_VERTEX;
      emitted_r <= '0;
    end else begin
      mode_r    <= mode_nxt;
      is_fan_r  <= is_fan_nxt;
      remain_r  <= remain_nxt;
      ord_r     <= ord_nxt;
      parity_r  <= parity_nxt;
      field_r   <= field_nxt;
      emitted_r <= emitted_nxt;
    end
  end

  // Record payload
  always_ff @(posedge clk) begin
    rv_r    <= rv_nxt;
    vok_r   <= vok_nxt;
    rn_r    <= rn_nxt;
    nok_r   <= nok_nxt;
    seam_r  <= seam_nxt;
    rs_r    <= rs_nxt;
    held0_r <= held0_nxt;
    held1_r <= held1_nxt;
    ok0_r   <= ok0_nxt;
    ok1_r   <= ok1_nxt;
  end

  assign mag  = word[WORD_W-1] ? ((WORD_W+1)'(17'h10000) - {1'b0, word}) : {1'b0, word};
  assign nadj = {1'b0, word[INDEX_W-1:0]} + {1'b0, cfg.normal_base};
  assign rec  = '{v: rv_r, n: rn_r, s: rs_r, t: word};
  assign rec_ok = vok_r & nok_r;

  // Parse words, adjust fields and emit jobs
  always_comb begin
    mode_nxt    = mode_r;
    is_fan_nxt  = is_fan_r;
    remain_nxt  = remain_r;
    ord_nxt     = ord_r;
    parity_nxt  = parity_r;
    field_nxt   = field_r;
    emitted_nxt = emitted_r;
    rv_nxt      = rv_r;
    vok_nxt     = vok_r;
    rn_nxt      = rn_r;
    nok_nxt     = nok_r;
    seam_nxt    = seam_r;
    rs_nxt      = rs_r;
    held0_nxt   = held0_r;
    held1_nxt   = held1_r;
    ok0_nxt     = ok0_r;
    ok1_nxt     = ok1_r;
    push        = 1'b0;
    push_job    = '{is_end: KIND_VERTEX, total: '0, vtx: {rec, held1_r, held0_r}};

    if (word_valid) begin
      unique case (mode_r)
        MODE_HEADER: begin
          if (word == '0) begin
            push            = 1'b1;
            push_job.is_end = KIND_END;
            push_job.total  = emitted_r;
            emitted_nxt     = '0;
          end else begin
            is_fan_nxt = word[WORD_W-1];
            remain_nxt = (mag < (WORD_W+1)'(2)) ? (WORD_W+1)'(2) : mag;
            ord_nxt    = '0;
            parity_nxt = 1'b0;
            field_nxt  = FLD_VERTEX;
            mode_nxt   = MODE_RECORD;
          end
        end
        MODE_RECORD: begin
          unique case (field_r)
            FLD_VERTEX: begin
              rv_nxt    = word[INDEX_W-1:0];
              vok_nxt   = word < {1'b0, cfg.vertex_limit};
              field_nxt = FLD_NORMAL;
            end
            FLD_NORMAL: begin
              seam_nxt  = word[WORD_W-1];
              rn_nxt    = nadj[INDEX_W-1:0];
              nok_nxt   = nadj < {1'b0, cfg.normal_limit};
              field_nxt = FLD_S;
            end
            FLD_S: begin
              rs_nxt    = seam_r ? (word + {2'b00, cfg.tex_width[CFG_W-1:1]}) : word;
              field_nxt = FLD_T;
            end
            FLD_T: begin
              field_nxt = FLD_VERTEX;
              if (ord_r == 2'd0) begin
                held0_nxt = rec;
                ok0_nxt   = rec_ok;
              end else if (ord_r == 2'd1) begin
                held1_nxt = rec;
                ok1_nxt   = rec_ok;
              end else begin
                if (ok0_r && ok1_r && rec_ok) begin
                  push = 1'b1;
                  // Swap the first two on odd strip steps
                  if (!is_fan_r && parity_r) begin
                    push_job.vtx = {rec, held0_r, held1_r};
                  end
                  emitted_nxt = (emitted_r > TOTAL_SAT) ? TOTAL_MAX
                                                        : emitted_r + TOTAL_W'(3);
                end
                if (!is_fan_r) begin
                  held0_nxt = held1_r;
                  ok0_nxt   = ok1_r;
                end
                held1_nxt = rec;
                ok1_nxt   = rec_ok;
              end
              ord_nxt    = (ord_r == 2'd2) ? ord_r : ord_r + 2'd1;
              parity_nxt = ~parity_r;
              remain_nxt = remain_r - (WORD_W+1)'(1);
              if (remain_r == (WORD_W+1)'(1)) begin
                mode_nxt = MODE_HEADER;
              end
            end
            default: field_nxt = FLD_VERTEX;
          endcase
        end
        default: mode_nxt = MODE_HEADER;
      endcase
    end
  end

endmodule

>>> hw/rtl/sfta_queue.sv
module sfta_queue
  import sfta_pkg::*;
#(
  parameter int unsigned DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  job_t    push_job,
  input  logic    pop,
  output job_t    head,
  output q_stat_t stat
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  job_t             mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt, rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign stat.full  = (cnt_r == CNT_W'(DEPTH));
  assign stat.valid = (cnt_r != '0);
  assign do_push    = push & ~stat.full;
  assign do_pop     = pop & stat.valid;
  assign head       = mem_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store the incoming job
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

>>> hw/rtl/sfta_back.sv
module sfta_back
  import sfta_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  job_t               head,
  input  q_stat_t            stat,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_kind,
  output logic               out_last,
  output vrec_t              out_vtx,
  output logic [TOTAL_W-1:0] out_total
);

  logic               valid_r, valid_nxt;
  logic [1:0]         sub_r, sub_nxt;
  logic               kind_r, kind_nxt;
  logic               last_r, last_nxt;
  vrec_t              vtx_r, vtx_nxt;
  logic [TOTAL_W-1:0] total_r, total_nxt;
  logic               load;

  assign load      = stat.valid & (~valid_r | out_ready);
  assign out_valid = valid_r;
  assign out_kind  = kind_r;
  assign out_last  = last_r;
  assign out_vtx   = vtx_r;
  assign out_total = total_r;

  // Unroll the head job into results, one per transfer
  always_comb begin
    valid_nxt = valid_r;
    sub_nxt   = sub_r;
    kind_nxt  = kind_r;
    last_nxt  = last_r;
    vtx_nxt   = vtx_r;
    total_nxt = total_r;
    pop       = 1'b0;

    if (valid_r && out_ready) begin
      valid_nxt = 1'b0;
    end
    if (load) begin
      valid_nxt = 1'b1;
      if (head.is_end == KIND_END) begin
        kind_nxt  = KIND_END;
        last_nxt  = 1'b1;
        vtx_nxt   = '0;
        total_nxt = head.total;
        pop       = 1'b1;
        sub_nxt   = '0;
      end else begin
        kind_nxt  = KIND_VERTEX;
        last_nxt  = (sub_r == 2'd2);
        vtx_nxt   = head.vtx[sub_r];
        total_nxt = '0;
        pop       = (sub_r == 2'd2);
        sub_nxt   = (sub_r == 2'd2) ? 2'd0 : sub_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      sub_r   <= '0;
    end else begin
      valid_r <= valid_nxt;
      sub_r   <= sub_nxt;
    end
  end

  // Output payload
  always_ff @(posedge clk) begin
    kind_r  <= kind_nxt;
    last_r  <= last_nxt;
    vtx_r   <= vtx_nxt;
    total_r <= total_nxt;
  end

endmodule

>>> hw/rtl/strip_fan_triangle_assembler.sv
// Channel | Dir | Handshake              | Payload
// in_     | in  | in_tvalid / in_tready  | tdata: cmd_word
// out_    | out | out_tvalid / out_tready| tdata: indices, s, t, total; tuser: kind; tlast
// cfg_    | in  | cfg_wr_en              | cfg_addr register index, cfg_wdata value
//
// One command word is taken per cycle while in_tready is high; a triangle needs four
// words and yields three results, which the back end issues through its output
// register one per cycle while out_tready is high, from a job queue (default depth 2).
// in_tready drops only while the job queue is full; out_tready stalls the back end.
// rst_n is synchronous and active low; registers reset to their listed defaults.
module strip_fan_triangle_assembler
  import sfta_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [15:0]        in_tdata,   // [15:0] cmd_word
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [87:0]        out_tdata,  // [14:0] vertex_index, [29:15] normal_index,
                                         // [45:30] s_coord, [61:46] t_coord,
                                         // [85:62] mesh_vertex_total, [87:86] zero
  output logic               out_tuser,  // [0] kind
  output logic               out_tlast,  // last_of_run
  input  logic               cfg_wr_en,
  input  logic [CFG_A_W-1:0] cfg_addr,
  input  logic [CFG_W-1:0]   cfg_wdata
);

  cfg_t               cfg_r, cfg_nxt;
  q_stat_t            stat;
  logic               push, pop;
  job_t               push_job, head;
  logic               word_valid;
  vrec_t              out_vtx;
  logic [TOTAL_W-1:0] out_total;

  // Configuration register writes
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_addr))
        CFG_TEX_WIDTH:    cfg_nxt.tex_width    = cfg_wdata;
        CFG_NORMAL_BASE:  cfg_nxt.normal_base  = cfg_wdata;
        CFG_VERTEX_LIMIT: cfg_nxt.vertex_limit = cfg_wdata;
        CFG_NORMAL_LIMIT: cfg_nxt.normal_limit = cfg_wdata;
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '{tex_width: CFG_W'(1), normal_base: '0, vertex_limit: '0,
                 normal_limit: '0};
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign in_tready  = ~stat.full;
  assign word_valid = in_tvalid & in_tready;

  sfta_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .word_valid (word_valid),
    .word       (in_tdata),
    .push       (push),
    .push_job   (push_job)
  );

  sfta_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .head     (head),
    .stat     (stat)
  );

  sfta_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .stat      (stat),
    .pop       (pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_kind  (out_tuser),
    .out_last  (out_tlast),
    .out_vtx   (out_vtx),
    .out_total (out_total)
  );

  // Pack the result fields, lowest first
  assign out_tdata = {2'b00, out_total, out_vtx.t, out_vtx.s, out_vtx.n, out_vtx.v};

endmodule

>>> test/tb.sv
`timescale 1ns / 1ps

module tb;
  import sfta_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 40_000;
  localparam int unsigned SETTLE      = 8;
  localparam int unsigned RAND_WORDS  = 240;
  localparam int unsigned PHASE_WORDS = 60;
  localparam int unsigned HOLD_CYCLES = 150;
  localparam logic [CFG_W-1:0] REG_MAX = '1;

  // Raw or seam-adjusted vertex record, 16 bits per field
  typedef struct packed {
    logic [WORD_W-1:0] v;
    logic [WORD_W-1:0] n;
    logic [WORD_W-1:0] s;
    logic [WORD_W-1:0] t;
  } rec4_t;

  // One result as it should appear on the out_ channel
  typedef struct packed {
    logic               kind;
    logic [INDEX_W-1:0] vi;
    logic [INDEX_W-1:0] ni;
    logic [WORD_W-1:0]  s;
    logic [WORD_W-1:0]  t;
    logic               last;
    logic [TOTAL_W-1:0] total;
  } res_t;

  // Directed stimulus row: a command word or a register write
  typedef struct packed {
    logic               is_reg;
    cfg_idx_t           sel;
    logic [WORD_W-1:0]  value;
    logic               typed;
    logic [TOTAL_W-1:0] total;
  } row_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_tvalid = 1'b0;
  logic               in_tready;
  logic [15:0]        in_tdata = '0;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [87:0]        out_tdata;
  logic               out_tuser;
  logic               out_tlast;
  logic               cfg_wr_en = 1'b0;
  logic [CFG_A_W-1:0] cfg_addr = '0;
  logic [CFG_W-1:0]   cfg_wdata = '0;

  // Typed expectation travelling with the word on offer
  logic               in_typed = 1'b0;
  logic [TOTAL_W-1:0] in_total = '0;

  // Idling control shared by both sides
  logic               steady = 1'b0;
  logic [7:0]         hold_token = '0;
  logic [7:0]         hold_seen = '0;
  int unsigned        hold_left = 0;

  int unsigned        cycles = 0;
  int unsigned        sent_words = 0;
  int unsigned        mismatches = 0;

  // Register copies
  logic [CFG_W-1:0]   tex_w = 15'd1;
  logic [CFG_W-1:0]   n_base = '0;
  logic [CFG_W-1:0]   v_lim = '0;
  logic [CFG_W-1:0]   n_lim = '0;

  // Assembler state
  mode_t              rec_mode = MODE_HEADER;
  logic               fan_run = 1'b0;
  logic [16:0]        left_cnt = '0;
  logic [15:0]        ordinal = '0;
  field_t             fpos = FLD_VERTEX;
  rec4_t              cur = '0;
  rec4_t              hold_a = '0;
  rec4_t              hold_b = '0;
  logic [TOTAL_W-1:0] mesh_total = '0;

  res_t               due_results[$];
  row_t               dir_rows[$];

  strip_fan_triangle_assembler dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  always #1 clk = ~clk;

  // Seam fix on s, then clear the seam bit and add the normal base
  function automatic rec4_t seam_adjust(rec4_t r);
    rec4_t o;
    o = r;
    if (r.n[15]) o.s = r.s + 16'(tex_w >> 1);
    o.n = {1'b0, r.n[14:0]} + {1'b0, n_base};
    return o;
  endfunction

  function automatic logic fits(rec4_t r);
    return !r.v[15] && (r.v[14:0] < v_lim) && !r.n[15] && (r.n[14:0] < n_lim);
  endfunction

  function automatic res_t vertex_res(rec4_t r, logic last);
    res_t o;
    o = '0;
    o.kind = KIND_VERTEX;
    o.vi = r.v[14:0];
    o.ni = r.n[14:0];
    o.s = r.s;
    o.t = r.t;
    o.last = last;
    return o;
  endfunction

  // Advance the assembler by one command word and queue the vertices it emits
  function automatic void assemble_word(logic [15:0] w, logic typed,
                                        logic [TOTAL_W-1:0] typed_total);
    res_t        e;
    rec4_t       r;
    logic [16:0] mag;
    e = '0;
    if (rec_mode == MODE_HEADER) begin
      if (w == '0) begin
        e.kind = KIND_END;
        e.last = 1'b1;
        e.total = typed ? typed_total : mesh_total;
        due_results.push_back(e);
        mesh_total = '0;
      end else begin
        mag = w[15] ? 17'h10000 - {1'b0, w} : {1'b0, w};
        fan_run = w[15];
        left_cnt = (mag < 17'd2) ? 17'd2 : mag;
        ordinal = '0;
        fpos = FLD_VERTEX;
        rec_mode = MODE_RECORD;
      end
      return;
    end
    case (fpos)
      FLD_VERTEX: cur.v = w;
      FLD_NORMAL: cur.n = w;
      FLD_S:      cur.s = w;
      default:    cur.t = w;
    endcase
    if (fpos != FLD_T) begin
      fpos = field_t'(fpos + 2'd1);
      return;
    end
    fpos = FLD_VERTEX;
    r = seam_adjust(cur);
    if (ordinal == 16'd0) begin
      hold_a = r;
    end else if (ordinal == 16'd1) begin
      hold_b = r;
    end else begin
      if (fits(hold_a) && fits(hold_b) && fits(r)) begin
        // odd strip steps swap the first two corners
        if (!fan_run && ordinal[0]) begin
          due_results.push_back(vertex_res(hold_b, 1'b0));
          due_results.push_back(vertex_res(hold_a, 1'b0));
        end else begin
          due_results.push_back(vertex_res(hold_a, 1'b0));
          due_results.push_back(vertex_res(hold_b, 1'b0));
        end
        due_results.push_back(vertex_res(r, 1'b1));
        mesh_total = (mesh_total > TOTAL_SAT) ? TOTAL_MAX : mesh_total + TOTAL_W'(3);
      end
      if (!fan_run) hold_a = hold_b;
      hold_b = r;
    end
    ordinal = ordinal + 16'd1;
    left_cnt = left_cnt - 17'd1;
    if (left_cnt == '0) rec_mode = MODE_HEADER;
  endfunction

  // Predict on every input transfer
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) assemble_word(in_tdata, in_typed, in_total);
  end

  // Compare each output transfer with the oldest expectation
  always @(posedge clk) begin : check_out
    res_t e;
    if (rst_n && out_tvalid && out_tready) begin
      if (due_results.size() == 0) begin
        $error("unexpected result: kind %0d tdata %h", out_tuser, out_tdata);
        mismatches++;
      end else begin
        e = due_results.pop_front();
        if (out_tuser !== e.kind) begin
          $error("kind: expected %0d actual %0d", e.kind, out_tuser);
          mismatches++;
        end
        if (out_tdata[14:0] !== e.vi) begin
          $error("vertex_index: expected %0d actual %0d", e.vi, out_tdata[14:0]);
          mismatches++;
        end
        if (out_tdata[29:15] !== e.ni) begin
          $error("normal_index: expected %0d actual %0d", e.ni, out_tdata[29:15]);
          mismatches++;
        end
        if (out_tdata[45:30] !== e.s) begin
          $error("s_coord: expected %h actual %h", e.s, out_tdata[45:30]);
          mismatches++;
        end
        if (out_tdata[61:46] !== e.t) begin
          $error("t_coord: expected %h actual %h", e.t, out_tdata[61:46]);
          mismatches++;
        end
        if (out_tlast !== e.last) begin
          $error("last_of_run: expected %0d actual %0d", e.last, out_tlast);
          mismatches++;
        end
        if (out_tdata[85:62] !== e.total) begin
          $error("mesh_vertex_total: expected %0d actual %0d", e.total, out_tdata[85:62]);
          mismatches++;
        end
      end
    end
  end

  // Receiver: random idling, a long hold-off on request, steady stretches
  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_token != hold_seen) begin
      hold_seen <= hold_token;
      hold_left <= HOLD_CYCLES;
      out_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (steady) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(0, 99) >= 28);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Offer one word, with random gaps, and hold it until the transfer
  task automatic send_word(input logic [15:0] w, input logic typed = 1'b0,
                           input logic [TOTAL_W-1:0] tot = '0);
    while (!steady && $urandom_range(0, 99) < 28) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= w;
    in_typed <= typed;
    in_total <= tot;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sent_words++;
  endtask

  // Stop offering and wait until every expected result has left the block
  task automatic drain();
    in_tvalid <= 1'b0;
    @(negedge clk);
    while (due_results.size() != 0) @(negedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t sel, input logic [CFG_W-1:0] val);
    cfg_wr_en <= 1'b1;
    cfg_addr <= sel;
    cfg_wdata <= val;
    case (sel)
      CFG_TEX_WIDTH:    tex_w = val;
      CFG_NORMAL_BASE:  n_base = val;
      CFG_VERTEX_LIMIT: v_lim = val;
      default:          n_lim = val;
    endcase
    @(posedge clk);
  endtask

  task automatic load_regs(input logic [CFG_W-1:0] tw, input logic [CFG_W-1:0] nb,
                           input logic [CFG_W-1:0] vl, input logic [CFG_W-1:0] nl);
    write_reg(CFG_TEX_WIDTH, tw);
    write_reg(CFG_NORMAL_BASE, nb);
    write_reg(CFG_VERTEX_LIMIT, vl);
    write_reg(CFG_NORMAL_LIMIT, nl);
    cfg_wr_en <= 1'b0;
  endtask

  // Four words of one vertex; pct_ok steers indices into range
  task automatic send_record(input int unsigned pct_ok);
    logic [15:0] v;
    logic [15:0] n;
    logic [14:0] target;
    if ($urandom_range(0, 99) < pct_ok && v_lim != '0)
      v = 16'($urandom_range(0, int'(v_lim) - 1));
    else
      v = 16'($urandom);
    if ($urandom_range(0, 99) < pct_ok && n_lim != '0) begin
      target = 15'($urandom_range(0, int'(n_lim) - 1));
      n = {1'($urandom_range(0, 1)), 15'(target - n_base)};
    end else begin
      n = 16'($urandom);
    end
    send_word(v);
    send_word(n);
    send_word(16'($urandom));
    send_word(16'($urandom));
  endtask

  // One to three strip or fan runs, then the end-of-mesh word, now and then twice
  task automatic send_mesh();
    int unsigned runs;
    int unsigned mag;
    int unsigned recs;
    logic [15:0] hdr;
    runs = $urandom_range(1, 3);
    repeat (runs) begin
      mag = $urandom_range(1, 7);
      hdr = $urandom_range(0, 1) ? 16'(-mag) : 16'(mag);
      recs = (mag < 2) ? 2 : mag;
      send_word(hdr);
      repeat (recs) send_record(85);
    end
    send_word('0);
    if ($urandom_range(0, 7) == 0) send_word('0);
  endtask

  task automatic add_word(input logic [15:0] w, input logic typed = 1'b0,
                          input logic [TOTAL_W-1:0] tot = '0);
    row_t r;
    r = '0;
    r.value = w;
    r.typed = typed;
    r.total = tot;
    dir_rows.push_back(r);
  endtask

  task automatic add_reg(input cfg_idx_t sel, input logic [CFG_W-1:0] val);
    row_t r;
    r = '0;
    r.is_reg = 1'b1;
    r.sel = sel;
    r.value = {1'b0, val};
    dir_rows.push_back(r);
  endtask

  task automatic add_rec(input logic [15:0] v, input logic [15:0] n,
                         input logic [15:0] s, input logic [15:0] t);
    add_word(v);
    add_word(n);
    add_word(s);
    add_word(t);
  endtask

  initial begin
    int unsigned phase;
    int unsigned start;
    int unsigned base_words;

    // Mesh end straight after reset carries a zero total
    add_word(16'h0000, 1'b1, 24'd0);
    add_reg(CFG_TEX_WIDTH, REG_MAX);
    add_reg(CFG_NORMAL_BASE, 15'd0);
    add_reg(CFG_VERTEX_LIMIT, REG_MAX);
    add_reg(CFG_NORMAL_LIMIT, REG_MAX);
    // Strip of four: two triangles, the second with swapped corners
    add_word(16'd4);
    add_rec(16'h0000, 16'h8000, 16'h7FFF, 16'h8000);
    add_rec(16'h7FFE, 16'h7FFE, 16'h8000, 16'h7FFF);
    add_rec(16'h0001, 16'h8001, 16'hFFFF, 16'h0000);
    add_rec(16'h0002, 16'h0003, 16'h0001, 16'hFFFF);
    add_word(16'h0000, 1'b1, 24'd6);
    // Short fan count still takes two records
    add_word(16'hFFFF);
    add_rec(16'hFFFF, 16'h7FFF, 16'h1234, 16'h5678);
    add_rec(16'h8000, 16'hFFFF, 16'h0000, 16'h0000);

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Walk the directed rows
    for (int i = 0; i < dir_rows.size(); i++) begin
      if (dir_rows[i].is_reg) begin
        if (i == 0 || !dir_rows[i-1].is_reg) drain();
        write_reg(dir_rows[i].sel, dir_rows[i].value[CFG_W-1:0]);
        if (i == dir_rows.size() - 1 || !dir_rows[i+1].is_reg) cfg_wr_en <= 1'b0;
      end else begin
        send_word(dir_rows[i].value, dir_rows[i].typed, dir_rows[i].total);
      end
    end

    // Random phases, each under its own register setting
    phase = 0;
    base_words = sent_words;
    forever begin
      drain();
      if (sent_words - base_words >= RAND_WORDS) break;
      case (phase)
        0: load_regs(15'd0, 15'd0, REG_MAX, REG_MAX);
        1: load_regs(REG_MAX, REG_MAX, REG_MAX, REG_MAX);
        2: load_regs(15'd1, 15'd0, 15'd0, 15'd0);
        default: load_regs(15'($urandom_range(0, 32767)), 15'($urandom_range(0, 64)),
                           15'($urandom_range(16, 32767)), 15'($urandom_range(16, 32767)));
      endcase
      // back-pressure the output while words keep coming
      if (phase == 0) hold_token <= hold_token + 8'd1;
      steady <= (phase == 3);
      start = sent_words;
      while (sent_words - start < PHASE_WORDS) send_mesh();
      phase++;
    end
    steady <= 1'b0;

    // Most negative header opens a fan; walk its first triangles
    load_regs(15'($urandom_range(0, 32767)), 15'd0, REG_MAX, REG_MAX);
    send_word(16'h8000);
    send_record(100);
    repeat (8) send_record(70);
    drain();

    if (mismatches == 0 && due_results.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
